### src/lobm_pkg.sv
package lobm_pkg;

	// Resting order entry as stored in the slot memory
	typedef struct packed {
		logic        side;      // 0 buy, 1 sell
		logic [15:0] order_id;
		logic [31:0] price;
		logic [31:0] remaining;
		logic [15:0] arrival;
	} slot_t;

	// Best entry of one side, as tracked by the scan unit
	typedef struct packed {
		logic        found;
		logic [15:0] age;
		slot_t       slot;
	} best_t;

	localparam int unsigned MAX_TRADES = 63;
	localparam int unsigned TRADE_CW   = 6;

	localparam logic [1:0] MODE_BUY    = 2'd0;
	localparam logic [1:0] MODE_SELL   = 2'd1;
	localparam logic [1:0] MODE_CANCEL = 2'd2;
	localparam logic [1:0] MODE_QUOTE  = 2'd3;

	localparam logic [2:0] ST_ACCEPTED  = 3'd0;
	localparam logic [2:0] ST_BAD_VALUE = 3'd1;
	localparam logic [2:0] ST_ID_USED   = 3'd2;
	localparam logic [2:0] ST_BOOK_FULL = 3'd3;
	localparam logic [2:0] ST_CANCELLED = 3'd4;
	localparam logic [2:0] ST_NOT_FOUND = 3'd5;
	localparam logic [2:0] ST_QUOTE     = 3'd6;

endpackage

### src/lobm_ram.sv
module lobm_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// One write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### src/lobm_scan.sv
module lobm_scan #(
	parameter int unsigned IW = 6
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            clr,
	input  logic            en,
	input  logic            entry_valid,
	input  lobm_pkg::slot_t entry,
	input  logic [IW-1:0]   idx,
	input  logic [15:0]     arrival_now,
	output lobm_pkg::best_t best_bid,
	output lobm_pkg::best_t best_ask,
	output logic [IW-1:0]   bid_idx,
	output logic [IW-1:0]   ask_idx
);

	import lobm_pkg::*;

	logic        found_q [2];
	logic [15:0] age_q   [2];
	slot_t       slot_q  [2];
	logic [IW-1:0] idx_q [2];
	logic [15:0] age;
	logic [1:0]  better;
	logic [1:0]  take;

	assign age = arrival_now - entry.arrival;

	// One price/age comparator per side, fed one entry per cycle
	always_comb begin
		for (int s = 0; s < 2; s++) begin
			better[s] = (s == 0) ? (entry.price > slot_q[s].price)
			                     : (entry.price < slot_q[s].price);
			take[s] = entry_valid && (entry.side == 1'(s)) &&
			          (!found_q[s] || better[s] ||
			           ((entry.price == slot_q[s].price) && (age > age_q[s])));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < 2; s++) begin
				found_q[s] <= 1'b0;
			end
		end else if (clr) begin
			for (int s = 0; s < 2; s++) begin
				found_q[s] <= 1'b0;
			end
		end else if (en) begin
			for (int s = 0; s < 2; s++) begin
				if (take[s]) begin
					found_q[s] <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!clr && en) begin
			for (int s = 0; s < 2; s++) begin
				if (take[s]) begin
					age_q[s]  <= age;
					slot_q[s] <= entry;
					idx_q[s]  <= idx;
				end
			end
		end
	end

	assign best_bid = '{found: found_q[0], age: age_q[0], slot: slot_q[0]};
	assign best_ask = '{found: found_q[1], age: age_q[1], slot: slot_q[1]};
	assign bid_idx  = idx_q[0];
	assign ask_idx  = idx_q[1];

endmodule

### src/limit_order_book_matcher_core.sv
// Price-time priority order book with one matching engine. One transaction at a
// time: every pass over the book scans the whole slot memory through one read port,
// one slot per cycle, after a setup state. A quote, a rejected value or a reused id
// runs one scan; a cancel runs two. An add runs one match scan per trade, one more
// when its trades do not fill it and the trade limit is not reached, then a
// free-slot search when a remainder is left, and the closing scan. Each trade and
// the closing status item go out through an output register; while out_stall holds
// that register, the sequencer waits. After reset the used-id memory is cleared one
// entry per cycle, with in_stall held high.
module limit_order_book_matcher_core #(
	parameter int unsigned MAX_RESTING = 63,
	parameter int unsigned ID_COUNT    = 65536
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  mode,
	input  logic [15:0] order_id,
	input  logic [31:0] limit_price,
	input  logic [31:0] quantity,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  status,
	output logic [15:0] buy_id,
	output logic [15:0] sell_id,
	output logic [31:0] trade_price,
	output logic [31:0] trade_qty,
	output logic [31:0] best_bid,
	output logic        bid_valid,
	output logic [31:0] best_ask,
	output logic        ask_valid,
	output logic [31:0] spread,
	output logic        last
);

	import lobm_pkg::*;

	localparam int unsigned IW = (MAX_RESTING > 1) ? $clog2(MAX_RESTING) : 1;
	localparam int unsigned CW = $clog2(MAX_RESTING + 1);
	localparam int unsigned MW = $clog2(ID_COUNT);
	localparam int unsigned SW = $bits(slot_t);

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_MAP_RD, S_MAP_CHK, S_SCAN_INIT, S_SCAN,
		S_TRADE, S_REST, S_FREE, S_STATUS
	} state_t;

	typedef enum logic [1:0] {K_MATCH, K_CANCEL, K_QUOTE} kind_t;

	state_t  state_q;
	kind_t   kind_q;
	logic [MW-1:0] clr_cnt_q;
	logic [CW-1:0] cnt_q;
	logic          vld_s1;
	logic [IW-1:0] idx_s1;

	logic [1:0]  mode_q;
	logic [15:0] id_q;
	logic [31:0] price_q;
	logic [31:0] rem_q;
	logic [31:0] fill_q;
	logic [2:0]  stat_q;
	logic [TRADE_CW-1:0] trades_q;
	logic [15:0] arrival_q;
	logic [MAX_RESTING-1:0] slot_valid_q;
	logic          cancel_found_q;
	logic [IW-1:0] cancel_idx_q;

	logic        out_valid_q;
	logic [2:0]  status_q;
	logic [15:0] buy_id_q, sell_id_q;
	logic [31:0] trade_price_q, trade_qty_q, best_bid_q, best_ask_q, spread_q;
	logic        bid_valid_q, ask_valid_q, last_q;

	// Used-id memory
	logic          map_we;
	logic [MW-1:0] map_waddr, map_idx;
	logic [0:0]    map_wdata, map_rdata;

	assign map_idx   = MW'(32'(id_q) % ID_COUNT);
	assign map_we    = (state_q == S_CLEAR) || ((state_q == S_MAP_CHK) && !map_rdata[0]);
	assign map_waddr = (state_q == S_CLEAR) ? clr_cnt_q : map_idx;
	assign map_wdata = (state_q == S_CLEAR) ? 1'b0 : 1'b1;

	lobm_ram #(.WIDTH(1), .DEPTH(ID_COUNT)) u_map (
		.clk(clk), .we(map_we), .waddr(map_waddr), .wdata(map_wdata),
		.raddr(map_idx), .rdata(map_rdata)
	);

	// Slot memory
	logic          slot_we;
	logic [IW-1:0] slot_waddr;
	slot_t         slot_wdata, slot_rdata;
	logic [SW-1:0] slot_rbits;

	best_t         bb, ba, opp;
	logic [IW-1:0] bb_idx, ba_idx, opp_idx;
	logic          scan_clr, scan_done, out_free, out_load, entry_valid;
	logic [31:0]   fill_d, rem_left, slot_left;

	assign slot_rdata = slot_t'(slot_rbits);

	always_comb begin
		slot_we    = 1'b0;
		slot_waddr = opp_idx;
		slot_wdata = opp.slot;
		slot_wdata.remaining = slot_left;
		if (state_q == S_TRADE) begin
			slot_we = out_free;
		end else if (state_q == S_FREE) begin
			slot_we    = (cnt_q < CW'(MAX_RESTING)) && !slot_valid_q[cnt_q[IW-1:0]];
			slot_waddr = cnt_q[IW-1:0];
			slot_wdata = '{side: mode_q[0], order_id: id_q, price: price_q,
			               remaining: rem_q, arrival: arrival_q};
		end
	end

	lobm_ram #(.WIDTH(SW), .DEPTH(MAX_RESTING)) u_slots (
		.clk(clk), .we(slot_we), .waddr(slot_waddr), .wdata(slot_wdata),
		.raddr(cnt_q[IW-1:0]), .rdata(slot_rbits)
	);

	// Best-of-side tracker over the scan stream
	assign scan_clr    = (state_q == S_SCAN_INIT);
	assign entry_valid = slot_valid_q[idx_s1];

	lobm_scan #(.IW(IW)) u_scan (
		.clk(clk), .arst_n(arst_n), .clr(scan_clr), .en(vld_s1),
		.entry_valid(entry_valid), .entry(slot_rdata), .idx(idx_s1),
		.arrival_now(arrival_q), .best_bid(bb), .best_ask(ba),
		.bid_idx(bb_idx), .ask_idx(ba_idx)
	);

	assign opp       = mode_q[0] ? bb : ba;
	assign opp_idx   = mode_q[0] ? bb_idx : ba_idx;
	assign scan_done = (state_q == S_SCAN) && (cnt_q == CW'(MAX_RESTING)) && !vld_s1;
	assign out_free  = !out_valid_q || !out_stall;
	assign out_load  = ((state_q == S_TRADE) || (state_q == S_STATUS)) && out_free;
	assign fill_d    = (rem_q < opp.slot.remaining) ? rem_q : opp.slot.remaining;
	assign rem_left  = rem_q - fill_q;
	assign slot_left = opp.slot.remaining - fill_q;
	assign in_stall  = (state_q != S_IDLE);

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_CLEAR;
			kind_q         <= K_QUOTE;
			clr_cnt_q      <= '0;
			cnt_q          <= '0;
			vld_s1         <= 1'b0;
			trades_q       <= '0;
			arrival_q      <= '0;
			slot_valid_q   <= '0;
			cancel_found_q <= 1'b0;
			out_valid_q    <= 1'b0;
		end else begin
			vld_s1 <= (state_q == S_SCAN) && (cnt_q < CW'(MAX_RESTING));
			// Output register: load a new trade or status item, or empty on acceptance
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					clr_cnt_q <= clr_cnt_q + 1'b1;
					if (clr_cnt_q == MW'(ID_COUNT - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_valid) begin
						trades_q <= '0;
						unique case (mode)
							MODE_BUY, MODE_SELL: begin
								if (limit_price == '0 || quantity == '0) begin
									stat_q  <= ST_BAD_VALUE;
									kind_q  <= K_QUOTE;
									state_q <= S_SCAN_INIT;
								end else begin
									state_q <= S_MAP_RD;
								end
							end
							MODE_CANCEL: begin
								kind_q  <= K_CANCEL;
								state_q <= S_SCAN_INIT;
							end
							default: begin
								stat_q  <= ST_QUOTE;
								kind_q  <= K_QUOTE;
								state_q <= S_SCAN_INIT;
							end
						endcase
					end
				end
				S_MAP_RD: state_q <= S_MAP_CHK;
				S_MAP_CHK: begin
					state_q <= S_SCAN_INIT;
					if (map_rdata[0]) begin
						stat_q <= ST_ID_USED;
						kind_q <= K_QUOTE;
					end else begin
						kind_q <= K_MATCH;
					end
				end
				S_SCAN_INIT: begin
					cnt_q          <= '0;
					cancel_found_q <= 1'b0;
					state_q        <= S_SCAN;
				end
				S_SCAN: begin
					if (cnt_q < CW'(MAX_RESTING)) begin
						cnt_q <= cnt_q + 1'b1;
					end
					// First resting order with the cancel id
					if (kind_q == K_CANCEL && vld_s1 && entry_valid && !cancel_found_q &&
					    slot_rdata.order_id == id_q) begin
						cancel_found_q <= 1'b1;
						cancel_idx_q   <= idx_s1;
					end
					if (scan_done) begin
						unique case (kind_q)
							K_MATCH: begin
								if (!opp.found ||
								    (mode_q == MODE_BUY && opp.slot.price > price_q) ||
								    (mode_q == MODE_SELL && opp.slot.price < price_q)) begin
									state_q <= S_REST;
								end else begin
									fill_q  <= fill_d;
									state_q <= S_TRADE;
								end
							end
							K_CANCEL: begin
								kind_q  <= K_QUOTE;
								state_q <= S_SCAN_INIT;
								if (cancel_found_q) begin
									slot_valid_q[cancel_idx_q] <= 1'b0;
									stat_q <= ST_CANCELLED;
								end else begin
									stat_q <= ST_NOT_FOUND;
								end
							end
							default: state_q <= S_STATUS;
						endcase
					end
				end
				S_TRADE: begin
					if (out_free) begin
						status_q      <= ST_ACCEPTED;
						buy_id_q      <= (mode_q == MODE_BUY) ? id_q : opp.slot.order_id;
						sell_id_q     <= (mode_q == MODE_BUY) ? opp.slot.order_id : id_q;
						trade_price_q <= opp.slot.price;
						trade_qty_q   <= fill_q;
						best_bid_q    <= '0;
						bid_valid_q   <= 1'b0;
						best_ask_q    <= '0;
						ask_valid_q   <= 1'b0;
						spread_q      <= '0;
						last_q        <= 1'b0;
						trades_q      <= trades_q + 1'b1;
						if (slot_left == '0) begin
							slot_valid_q[opp_idx] <= 1'b0;
						end
						if (rem_left == '0 || trades_q == TRADE_CW'(MAX_TRADES - 1)) begin
							state_q <= S_REST;
						end else begin
							state_q <= S_SCAN_INIT;
						end
					end
				end
				S_REST: begin
					cnt_q <= '0;
					if (rem_q == '0) begin
						stat_q  <= ST_ACCEPTED;
						kind_q  <= K_QUOTE;
						state_q <= S_SCAN_INIT;
					end else begin
						state_q <= S_FREE;
					end
				end
				S_FREE: begin
					if (cnt_q == CW'(MAX_RESTING)) begin
						stat_q  <= ST_BOOK_FULL;
						kind_q  <= K_QUOTE;
						state_q <= S_SCAN_INIT;
					end else if (!slot_valid_q[cnt_q[IW-1:0]]) begin
						slot_valid_q[cnt_q[IW-1:0]] <= 1'b1;
						arrival_q <= arrival_q + 1'b1;
						stat_q    <= ST_ACCEPTED;
						kind_q    <= K_QUOTE;
						state_q   <= S_SCAN_INIT;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_STATUS: begin
					if (out_free) begin
						status_q      <= stat_q;
						buy_id_q      <= '0;
						sell_id_q     <= '0;
						trade_price_q <= '0;
						trade_qty_q   <= '0;
						best_bid_q    <= bb.found ? bb.slot.price : '0;
						bid_valid_q   <= bb.found;
						best_ask_q    <= ba.found ? ba.slot.price : '0;
						ask_valid_q   <= ba.found;
						spread_q      <= (bb.found && ba.found) ?
						                 (ba.slot.price - bb.slot.price) : '0;
						last_q        <= 1'b1;
						state_q       <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Input transaction capture; the remainder shrinks with each trade
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) begin
			mode_q  <= mode;
			id_q    <= order_id;
			price_q <= limit_price;
			rem_q   <= quantity;
		end else if (state_q == S_TRADE && out_free) begin
			rem_q   <= rem_left;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= cnt_q[IW-1:0];
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign buy_id      = buy_id_q;
	assign sell_id     = sell_id_q;
	assign trade_price = trade_price_q;
	assign trade_qty   = trade_qty_q;
	assign best_bid    = best_bid_q;
	assign bid_valid   = bid_valid_q;
	assign best_ask    = best_ask_q;
	assign ask_valid   = ask_valid_q;
	assign spread      = spread_q;
	assign last        = last_q;

`ifndef NO_ASSERTIONS
	// An accepted transaction keeps the block busy on the next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input accepted twice in a row");

	// Trade count never exceeds the per-step limit
	a_trade_limit: assert property (@(posedge clk) disable iff (!arst_n)
		trades_q <= TRADE_CW'(MAX_TRADES))
		else $error("trade limit exceeded");

	// A match scan only runs with quantity left
	a_match_rem: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN && kind_q == K_MATCH) |-> (rem_q != '0))
		else $error("match scan with zero remainder");

	// A trade always refers to a found, nonzero fill
	a_trade_found: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_TRADE) |-> (opp.found && fill_q != '0))
		else $error("trade without a resting order");
`endif

endmodule

### test/limit_order_book_matcher_core_test.sv
module limit_order_book_matcher_core_test;
	timeunit 1ns;
	timeprecision 1ps;
	import lobm_pkg::*;

	localparam int unsigned BOOK_DEPTH = 63;
	localparam int unsigned CYCLE_LIMIT = 8000000;
	localparam int unsigned WANT_DEPTH = 1024;

	typedef struct packed {
		logic [2:0]  status;
		logic [15:0] buy_id;
		logic [15:0] sell_id;
		logic [31:0] trade_price;
		logic [31:0] trade_qty;
		logic [31:0] best_bid;
		logic        bid_valid;
		logic [31:0] best_ask;
		logic        ask_valid;
		logic [31:0] spread;
		logic        last;
	} fill_report_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [1:0] mode = MODE_QUOTE;
	logic [15:0] order_id = '0;
	logic [31:0] limit_price = '0;
	logic [31:0] quantity = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [2:0] status;
	logic [15:0] buy_id, sell_id;
	logic [31:0] trade_price, trade_qty, best_bid, best_ask, spread;
	logic bid_valid, ask_valid, last;

	limit_order_book_matcher_core dut (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.mode(mode), .order_id(order_id), .limit_price(limit_price),
		.quantity(quantity), .out_valid(out_valid), .out_stall(out_stall),
		.status(status), .buy_id(buy_id), .sell_id(sell_id),
		.trade_price(trade_price), .trade_qty(trade_qty), .best_bid(best_bid),
		.bid_valid(bid_valid), .best_ask(best_ask), .ask_valid(ask_valid),
		.spread(spread), .last(last)
	);

	always #2 clk = ~clk;

	// book shadow
	logic        bk_live [BOOK_DEPTH];
	logic        bk_side [BOOK_DEPTH];
	logic [15:0] bk_id [BOOK_DEPTH];
	logic [31:0] bk_price [BOOK_DEPTH];
	logic [31:0] bk_left [BOOK_DEPTH];
	logic [15:0] bk_stamp [BOOK_DEPTH];
	logic [15:0] stamp_now;
	bit          id_taken [65536];

	// expected results, ring buffer
	fill_report_t want_buf [WANT_DEPTH];
	int unsigned want_wr = 0;
	int unsigned want_rd = 0;
	int unsigned error_count = 0;
	int unsigned cycle_count = 0;
	bit hold_receiver = 1'b0;
	bit quiet = 1'b0;
	logic [15:0] fresh_id = 16'd1000;

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		$display("mismatch %s: got %0h want %0h", what, got, want);
		error_count++;
	endtask

	function automatic void log_result(input fill_report_t r);
		want_buf[want_wr % WANT_DEPTH] = r;
		want_wr++;
	endfunction

	// best resting slot on one side, price then age then lowest index
	function automatic int top_of_book(input logic side);
		int best = -1;
		logic [15:0] best_age = 0;
		logic [15:0] age;
		for (int i = 0; i < BOOK_DEPTH; i++) begin
			if (!bk_live[i] || bk_side[i] != side)
				continue;
			age = stamp_now - bk_stamp[i];
			if (best < 0) begin
				best = i;
				best_age = age;
			end else if ((side == 1'b0 ? bk_price[i] > bk_price[best] :
					bk_price[i] < bk_price[best]) ||
					(bk_price[i] == bk_price[best] && age > best_age)) begin
				best = i;
				best_age = age;
			end
		end
		return best;
	endfunction

	// book step: queues trades and the closing quote
	task automatic book_step(input logic [1:0] md, input logic [15:0] id,
			input logic [31:0] px, input logic [31:0] qty);
		fill_report_t r;
		logic [2:0] st;
		logic [31:0] rem, fill;
		int b, f, bb, ba, n;
		n = 0;
		if (md == MODE_BUY || md == MODE_SELL) begin
			if (px == 0 || qty == 0)
				st = ST_BAD_VALUE;
			else if (id_taken[id])
				st = ST_ID_USED;
			else begin
				id_taken[id] = 1'b1;
				rem = qty;
				while (rem > 0 && n < MAX_TRADES) begin
					b = top_of_book(~md[0]);
					if (b < 0)
						break;
					if (md == MODE_BUY && bk_price[b] > px)
						break;
					if (md == MODE_SELL && bk_price[b] < px)
						break;
					fill = rem < bk_left[b] ? rem : bk_left[b];
					r = '0;
					r.buy_id = md == MODE_BUY ? id : bk_id[b];
					r.sell_id = md == MODE_BUY ? bk_id[b] : id;
					r.trade_price = bk_price[b];
					r.trade_qty = fill;
					log_result(r);
					n++;
					rem -= fill;
					bk_left[b] -= fill;
					if (bk_left[b] == 0)
						bk_live[b] = 1'b0;
				end
				st = ST_ACCEPTED;
				if (rem > 0) begin
					f = -1;
					for (int i = 0; i < BOOK_DEPTH; i++)
						if (!bk_live[i]) begin
							f = i;
							break;
						end
					if (f < 0)
						st = ST_BOOK_FULL;
					else begin
						bk_live[f] = 1'b1;
						bk_side[f] = md[0];
						bk_id[f] = id;
						bk_price[f] = px;
						bk_left[f] = rem;
						bk_stamp[f] = stamp_now;
						stamp_now++;
					end
				end
			end
		end else if (md == MODE_CANCEL) begin
			st = ST_NOT_FOUND;
			for (int i = 0; i < BOOK_DEPTH; i++)
				if (bk_live[i] && bk_id[i] == id) begin
					bk_live[i] = 1'b0;
					st = ST_CANCELLED;
					break;
				end
		end else
			st = ST_QUOTE;
		bb = top_of_book(1'b0);
		ba = top_of_book(1'b1);
		r = '0;
		r.status = st;
		r.best_bid = bb >= 0 ? bk_price[bb] : 0;
		r.bid_valid = bb >= 0;
		r.best_ask = ba >= 0 ? bk_price[ba] : 0;
		r.ask_valid = ba >= 0;
		r.spread = (bb >= 0 && ba >= 0) ? r.best_ask - r.best_bid : 0;
		r.last = 1'b1;
		log_result(r);
	endtask

	// send one transaction after a random gap; valid stays up when no gap follows
	task automatic send_order(input logic [1:0] md, input logic [15:0] id,
			input logic [31:0] px, input logic [31:0] qty);
		int gap;
		gap = quiet ? 0 : $urandom_range(11);
		if ($urandom_range(3) == 0)
			gap = 0;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		mode <= md;
		order_id <= id;
		limit_price <= px;
		quantity <= qty;
		book_step(md, id, px, qty);
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	task automatic drain;
		in_valid <= 1'b0;
		while (want_wr != want_rd)
			@(posedge clk);
		repeat (BOOK_DEPTH * 4) @(posedge clk);
	endtask

	function automatic logic [15:0] next_id;
		fresh_id++;
		return fresh_id;
	endfunction

	// result checker
	always @(posedge clk) begin
		fill_report_t got, want;
		if (arst_n && out_valid && !out_stall) begin
			got = {status, buy_id, sell_id, trade_price, trade_qty, best_bid,
				bid_valid, best_ask, ask_valid, spread, last};
			if (want_wr == want_rd)
				report("unexpected transaction", 0, 0);
			else begin
				want = want_buf[want_rd % WANT_DEPTH];
				want_rd++;
				if (got.status !== want.status) report("status", got.status, want.status);
				if (got.buy_id !== want.buy_id) report("buy_id", got.buy_id, want.buy_id);
				if (got.sell_id !== want.sell_id) report("sell_id", got.sell_id, want.sell_id);
				if (got.trade_price !== want.trade_price)
					report("trade_price", got.trade_price, want.trade_price);
				if (got.trade_qty !== want.trade_qty)
					report("trade_qty", got.trade_qty, want.trade_qty);
				if (got.best_bid !== want.best_bid)
					report("best_bid", got.best_bid, want.best_bid);
				if (got.bid_valid !== want.bid_valid)
					report("bid_valid", got.bid_valid, want.bid_valid);
				if (got.best_ask !== want.best_ask)
					report("best_ask", got.best_ask, want.best_ask);
				if (got.ask_valid !== want.ask_valid)
					report("ask_valid", got.ask_valid, want.ask_valid);
				if (got.spread !== want.spread) report("spread", got.spread, want.spread);
				if (got.last !== want.last) report("last", got.last, want.last);
			end
		end
	end

	// receiver stall: random per output item, or a long hold-off
	initial begin
		int wait_cycles;
		forever begin
			@(posedge clk);
			if (hold_receiver) begin
				out_stall <= 1'b1;
				repeat (1500) @(posedge clk);
				out_stall <= 1'b0;
				hold_receiver = 1'b0;
			end else if (out_valid && !out_stall) begin
				wait_cycles = quiet ? 0 : $urandom_range(11);
				if (wait_cycles != 0) begin
					out_stall <= 1'b1;
					repeat (wait_cycles) @(posedge clk);
					out_stall <= 1'b0;
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	task automatic test_directed;
		logic [15:0] a, b;
		send_order(MODE_QUOTE, 16'hFFFF, '1, '1);
		send_order(MODE_BUY, 16'd1, 32'd0, 32'd5);
		send_order(MODE_SELL, 16'd1, 32'd5, 32'd0);
		send_order(MODE_BUY, 16'd1, 32'd100, 32'd10);
		send_order(MODE_BUY, 16'd1, 32'd100, 32'd10);
		send_order(MODE_BUY, 16'd2, 32'd100, 32'd7);
		send_order(MODE_BUY, 16'd3, 32'd101, 32'd3);
		send_order(MODE_SELL, 16'd4, 32'd90, 32'd15);
		send_order(MODE_SELL, 16'd5, 32'hFFFFFFFF, 32'hFFFFFFFF);
		send_order(MODE_BUY, 16'hFFFF, 32'hFFFFFFFF, 32'd1);
		send_order(MODE_CANCEL, 16'd2, '1, '1);
		send_order(MODE_CANCEL, 16'd2, 32'd0, 32'd0);
		send_order(MODE_CANCEL, 16'd4, 32'd0, 32'd0);
		send_order(MODE_BUY, 16'd0, 32'd1, 32'd1);
		send_order(MODE_SELL, 16'd6, 32'd1, 32'd2);
		send_order(MODE_QUOTE, 16'd0, 32'd0, 32'd0);
		drain();
		// fill the book, then overflow it
		for (int i = 0; i < BOOK_DEPTH; i++) begin
			a = next_id();
			send_order(MODE_BUY, a, 32'd10 + $urandom_range(3), 32'd1 + $urandom_range(4));
		end
		b = next_id();
		send_order(MODE_BUY, b, 32'd9, 32'd4);
		// sweep most of the book with one large sell
		send_order(MODE_SELL, next_id(), 32'd1, 32'hFFFFFFF0);
		drain();
	endtask

	task automatic test_random;
		logic [1:0] md;
		logic [15:0] id;
		logic [31:0] px, qty;
		for (int i = 0; i < 120; i++) begin
			md = $urandom_range(3);
			if ($urandom_range(9) == 0)
				md = MODE_QUOTE;
			else if ($urandom_range(4) == 0)
				md = MODE_CANCEL;
			else
				md = $urandom_range(1);
			id = $urandom_range(3) == 0 ? 16'($urandom) : fresh_id - 16'($urandom_range(30));
			if (md <= MODE_SELL && $urandom_range(5) != 0)
				id = next_id();
			px = $urandom_range(15) == 0 ? $urandom : 32'd1000 + $urandom_range(20);
			if ($urandom_range(30) == 0)
				px = 0;
			qty = $urandom_range(15) == 0 ? $urandom : 32'd1 + $urandom_range(50);
			if ($urandom_range(30) == 0)
				qty = 0;
			send_order(md, id, px, qty);
			if (i == 60)
				hold_receiver = 1'b1;
			if (i == 90)
				drain();
		end
	endtask

	task automatic test_back_to_back;
		quiet = 1'b1;
		for (int i = 0; i < 20; i++)
			send_order(i[0] ? MODE_SELL : MODE_BUY, next_id(), 32'd1005, 32'd3);
		quiet = 1'b0;
	endtask

	initial begin
		for (int i = 0; i < BOOK_DEPTH; i++) begin
			bk_live[i] = 1'b0;
			bk_side[i] = 1'b0;
			bk_id[i] = '0;
			bk_price[i] = '0;
			bk_left[i] = '0;
			bk_stamp[i] = '0;
		end
		stamp_now = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random();
		test_back_to_back();
		drain();
		if (error_count == 0 && want_wr == want_rd)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end
endmodule
